// File: src/xml_byte_escaper_defines.svh
// Assertion helpers for the XML byte escaper.
`ifndef XML_BYTE_ESCAPER_DEFINES_SVH
`define XML_BYTE_ESCAPER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define XBE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define XBE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/xbe_pkg.sv
package xbe_pkg;

    localparam int RUN_MAX = 19;
    localparam int POS_W   = 32;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    localparam logic [8*14-1:0] CHAR_HEAD = "<char code=\"0x";
    localparam logic [8*3-1:0]  CHAR_TAIL = "\"/>";

    typedef enum logic [2:0] {
        K_PASS,
        K_AMP,
        K_QUOT,
        K_APOS,
        K_LT,
        K_GT,
        K_CHAR,
        K_DEC
    } t_kind;

    // One classified input byte: how to expand it and where it sits in the stream.
    typedef struct packed {
        t_kind             kind;
        logic [7:0]        c;
        logic [7:0]        d0;
        logic [7:0]        d1;
        logic [7:0]        d2;
        logic [4:0]        last;
        logic [POS_W-1:0]  pos;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Byte idx of the expansion of d; strings are left-aligned in a RUN_MAX-byte word.
    function automatic logic [7:0] xbe_out_byte(input t_desc d, input logic [4:0] idx);
        logic [8*RUN_MAX-1:0] s;
        logic [4:0]           k;
        k = 5'(RUN_MAX - 1) - idx;
        case (d.kind)
            K_PASS:  s = {d.c, {18{8'h00}}};
            K_AMP:   s = {"&amp;", {14{8'h00}}};
            K_QUOT:  s = {"&quot;", {13{8'h00}}};
            K_APOS:  s = {"&apos;", {13{8'h00}}};
            K_LT:    s = {"&lt;", {15{8'h00}}};
            K_GT:    s = {"&gt;", {15{8'h00}}};
            K_CHAR:  s = {CHAR_HEAD, d.d0, d.d1, CHAR_TAIL};
            K_DEC:   s = {"&#", d.d0, d.d1, d.d2, ";", {13{8'h00}}};
            default: s = '0;
        endcase
        return s[{k, 3'b000} +: 8];
    endfunction

endpackage

// File: src/xbe_front.sv
module xbe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_cmd,
    input  logic [7:0]    i_byte,
    input  logic          i_q_full,
    output logic          o_ready,
    output logic          o_push,
    output xbe_pkg::t_desc o_desc
);
    import xbe_pkg::*;

    logic                r_at_line_start;
    logic [POS_W-1:0]    r_count;
    logic                n_at_line_start;
    logic [POS_W-1:0]    n_count;

    logic                w_accept;
    logic                w_emit;
    logic [7:0]          w_c;
    logic [1:0]          w_hund;
    logic [6:0]          w_rem;
    logic [14:0]         w_prod;
    logic [3:0]          w_tens;
    logic [3:0]          w_ones;
    t_desc               w_desc;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
    endfunction

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    // End of line on an empty line produces nothing and leaves state alone.
    assign w_emit   = w_accept && !(i_cmd == CMD_EOL && r_at_line_start);
    assign w_c      = (i_cmd == CMD_EOL) ? CH_LF : i_byte;

    // Decimal digits; the reciprocal 205/2048 is exact for values below 100.
    always_comb begin
        w_hund = (w_c >= 8'd200) ? 2'd2 : ((w_c >= 8'd100) ? 2'd1 : 2'd0);
        w_rem  = 7'(w_c - 8'(w_hund) * 8'd100);
        w_prod = 15'(w_rem) * 15'd205;
        w_tens = w_prod[14:11];
        w_ones = 4'(w_rem - 7'(w_tens) * 7'd10);
    end

    always_comb begin
        n_count         = r_count + 32'd1;
        n_at_line_start = (w_c == CH_LF);

        w_desc.c    = w_c;
        w_desc.pos  = n_count;
        w_desc.d0   = 8'h00;
        w_desc.d1   = 8'h00;
        w_desc.d2   = 8'h00;
        w_desc.kind = K_PASS;
        w_desc.last = 5'd0;
        if (w_c == CH_LF || w_c == CH_TAB || w_c == CH_SPACE) begin
            w_desc.kind = K_PASS;
        end else if (w_c == "&") begin
            w_desc.kind = K_AMP;
            w_desc.last = 5'd4;
        end else if (w_c == "\"") begin
            w_desc.kind = K_QUOT;
            w_desc.last = 5'd5;
        end else if (w_c == "'") begin
            w_desc.kind = K_APOS;
            w_desc.last = 5'd5;
        end else if (w_c == "<") begin
            w_desc.kind = K_LT;
            w_desc.last = 5'd3;
        end else if (w_c == ">") begin
            w_desc.kind = K_GT;
            w_desc.last = 5'd3;
        end else if (w_c >= CH_SPACE && w_c <= CH_TILDE) begin
            w_desc.kind = K_PASS;
        end else if (w_c < CH_SPACE) begin
            w_desc.kind = K_CHAR;
            w_desc.last = 5'(RUN_MAX - 1);
            w_desc.d0   = hex_char(w_c[7:4]);
            w_desc.d1   = hex_char(w_c[3:0]);
        end else begin
            w_desc.kind = K_DEC;
            w_desc.last = 5'd5;
            w_desc.d0   = 8'h30 + {6'h00, w_hund};
            w_desc.d1   = 8'h30 + {4'h0, w_tens};
            w_desc.d2   = 8'h30 + {4'h0, w_ones};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_line_start <= 1'b1;
            r_count         <= '0;
        end else if (w_emit) begin
            r_at_line_start <= n_at_line_start;
            r_count         <= n_count;
        end
    end

    assign o_push = w_emit;
    assign o_desc = w_desc;

endmodule

// File: src/xbe_fifo.sv
module xbe_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  xbe_pkg::t_desc  i_desc,
    input  logic            i_pop,
    output xbe_pkg::t_desc  o_head,
    output xbe_pkg::t_q_stat o_stat
);
    import xbe_pkg::*;

    t_desc      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

// File: src/xbe_back.sv
module xbe_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  xbe_pkg::t_desc  i_head,
    input  logic            i_empty,
    output logic            o_pop,
    input  logic            i_ready,
    output logic            o_valid,
    output logic [39:0]     o_data,
    output logic            o_last
);
    import xbe_pkg::*;

    logic        r_valid;
    logic [39:0] r_data;
    logic        r_last;
    logic [4:0]  r_idx;

    logic        w_load;
    logic        w_take;
    logic        w_end;

    assign w_load = !r_valid || i_ready;
    assign w_take = w_load && !i_empty;
    assign w_end  = (r_idx == i_head.last);
    assign o_pop  = w_take && w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 5'd0;
        end else if (w_take) begin
            r_valid <= 1'b1;
            r_idx   <= w_end ? 5'd0 : (r_idx + 5'd1);
        end else if (w_load) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data <= {i_head.pos, xbe_out_byte(i_head, r_idx)};
            r_last <= w_end;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

// File: src/xml_byte_escaper.sv
// XML byte escaper.
// Input stream (s side): one transaction per raw byte; tuser is the command
// (0 = encode tdata, 1 = end of line, which emits a newline only when the
// current line holds something). tdata[7:0] is the byte.
// Output stream (m side): one transaction per escaped byte; tdata[7:0] is the
// byte, tdata[39:8] the count of output-producing inputs including this one,
// tlast marks the final byte of the run caused by one input transaction.
// The front end classifies a byte in the accept cycle and queues it in a
// two-entry queue; the back end expands it one output byte per cycle while
// the receiver is ready. Each output byte is registered in the back end.
// Throughput: the back end produces one byte per cycle while the receiver is
// ready; an input whose escape is N bytes long (1, 4, 5, 6 or 19) holds it
// for N output bytes; plain bytes stream at one per cycle while the receiver
// is ready. Input is accepted while the queue has room. An end of line on an
// empty line is accepted and produces nothing.
// Reset clears the queue and output valid, sets the line-start flag and
// zeroes the byte count. When the receiver stalls, the output holds and the
// queue fills, after which tready drops.
`include "xml_byte_escaper_defines.svh"

module xml_byte_escaper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tuser,   // [0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] out_byte, [39:8] byte_position
    output logic        o_m_tlast
);
    import xbe_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_desc   w_desc;
    t_desc   w_head;
    t_q_stat w_stat;

    xbe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_cmd    (i_s_tuser),
        .i_byte   (i_s_tdata),
        .i_q_full (w_stat.full),
        .o_ready  (o_s_tready),
        .o_push   (w_push),
        .o_desc   (w_desc)
    );

    xbe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_desc),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    xbe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_stat.empty),
        .o_pop   (w_pop),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_data  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

    `XBE_ASSERT_IMP(a_no_push_full, w_push, !w_stat.full, "push into full queue")
    `XBE_ASSERT_IMP(a_no_pop_empty, w_pop, !w_stat.empty, "pop from empty queue")
    `XBE_ASSERT_NEXT(a_run_no_gap, o_m_tvalid && i_m_tready && !o_m_tlast, o_m_tvalid, "gap inside a run")
    `XBE_ASSERT_NEXT(a_run_same_pos, o_m_tvalid && i_m_tready && !o_m_tlast, o_m_tdata[39:8] == $past(o_m_tdata[39:8]), "position changed inside a run")

endmodule

// File: sim/tb_xml_byte_escaper.sv
`timescale 1ns / 1ps

module tb_xml_byte_escaper;
    import xbe_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 200;
    localparam int DRAIN_CYCLES = 6;

    // {cmd, in_byte}
    localparam logic [8:0] DIRECTED [23] = '{
        {CMD_EOL,  8'h00},  // end of line right after reset: nothing
        {CMD_DATA, 8'h00},
        {CMD_DATA, 8'h1F},
        {CMD_DATA, 8'h09},  // tab
        {CMD_DATA, 8'h20},
        {CMD_DATA, 8'h7E},
        {CMD_DATA, 8'h7F},
        {CMD_DATA, 8'hFF},
        {CMD_DATA, 8'h80},
        {CMD_DATA, 8'h26},  // &
        {CMD_DATA, 8'h22},  // "
        {CMD_DATA, 8'h27},  // '
        {CMD_DATA, 8'h3C},  // <
        {CMD_DATA, 8'h3E},  // >
        {CMD_DATA, 8'h41},
        {CMD_EOL,  8'hFF},  // line holds text: newline
        {CMD_EOL,  8'h55},  // line now empty: nothing
        {CMD_DATA, 8'h0A},  // newline passes through
        {CMD_EOL,  8'h00},
        {CMD_DATA, 8'h64},
        {CMD_DATA, 8'hC8},
        {CMD_DATA, 8'h0D},
        {CMD_EOL,  8'hAA}
    };

    typedef struct {
        logic [7:0]       ch;
        logic             last;
        logic [POS_W-1:0] pos;
    } t_esc_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] in_byte
    logic        s_tuser = 1'b0; // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // [7:0] out_byte, [39:8] byte_position
    logic        m_tlast;

    t_esc_beat        escaped_q[$];
    logic [7:0]       esc_run[$];
    logic             line_start = 1'b1;
    logic [POS_W-1:0] byte_count = '0;
    string            hex_digits = "0123456789ABCDEF";

    int  errors = 0;
    int  cycles = 0;
    int  escaped_items = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    int  hold_req = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    xml_byte_escaper u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) esc_run.push_back(s[i]);
    endfunction

    // Expected escape sequence of one input transaction; returns run length.
    function automatic int predict_escape(logic cmd, logic [7:0] in_byte);
        logic [7:0] c;
        esc_run.delete();
        if (cmd == CMD_EOL) begin
            if (line_start) return 0;
            c = CH_LF;
        end else begin
            c = in_byte;
        end
        byte_count = byte_count + 1'b1;
        line_start = (c == CH_LF);

        if (c == CH_LF || c == CH_TAB || c == CH_SPACE) esc_run.push_back(c);
        else if (c == 8'h26) add_text("&amp;");
        else if (c == 8'h22) add_text("&quot;");
        else if (c == 8'h27) add_text("&apos;");
        else if (c == 8'h3C) add_text("&lt;");
        else if (c == 8'h3E) add_text("&gt;");
        else if (c >= CH_SPACE && c <= CH_TILDE) esc_run.push_back(c);
        else if (c < CH_SPACE) begin
            add_text("<char code=\"0x");
            esc_run.push_back(hex_digits[c[7:4]]);
            esc_run.push_back(hex_digits[c[3:0]]);
            add_text("\"/>");
        end else begin
            add_text("&#");
            esc_run.push_back(8'(8'h30 + c / 100));
            esc_run.push_back(8'(8'h30 + (c / 10) % 10));
            esc_run.push_back(8'(8'h30 + c % 10));
            add_text(";");
        end

        foreach (esc_run[k])
            escaped_q.push_back('{esc_run[k], k == esc_run.size() - 1, byte_count});
        return esc_run.size();
    endfunction

    task automatic send_item(logic cmd, logic [7:0] in_byte);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= in_byte;
        do @(posedge i_clk); while (!s_tready);
        if (predict_escape(cmd, in_byte) > 0) escaped_items++;
    endtask

    task automatic tx_gap();
        int n;
        int r;
        r = $urandom_range(99);
        if (tx_quiet || r < 60) n = 0;
        else if (r < 92) n = $urandom_range(1, 3);
        else n = $urandom_range(8, 30);
        repeat (n) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (escaped_q.size() != 0) @(posedge i_clk);
    endtask

    // Output side: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        int r;
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rx_quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            r = $urandom_range(99);
            if (r < 75) begin
                m_tready <= 1'b1;
            end else begin
                stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                m_tready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_esc_beat e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (escaped_q.size() == 0) begin
                $error("unexpected transaction: out_byte %h", m_tdata[7:0]);
                errors++;
            end else begin
                e = escaped_q.pop_front();
                if (m_tdata[7:0] !== e.ch) begin
                    $error("out_byte: expected %h, got %h", e.ch, m_tdata[7:0]);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_of_run: expected %b, got %b", e.last, m_tlast);
                    errors++;
                end
                if (m_tdata[39:8] !== e.pos) begin
                    $error("byte_position: expected %0d, got %0d", e.pos, m_tdata[39:8]);
                    errors++;
                end
            end
        end
    end

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 8'($urandom_range(8'h20, 8'h7E));
        if (r < 67) begin
            case ($urandom_range(4))
                0: return 8'h26;
                1: return 8'h22;
                2: return 8'h27;
                3: return 8'h3C;
                default: return 8'h3E;
            endcase
        end
        if (r < 72) return CH_TAB;
        if (r < 82) return 8'($urandom_range(8'h00, 8'h1F));
        if (r < 92) return 8'($urandom_range(8'h7F, 8'hFF));
        return 8'($urandom_range(255));
    endfunction

    task automatic test_directed();
        rx_quiet = 1'b0;
        foreach (DIRECTED[i]) begin
            send_item(DIRECTED[i][8], DIRECTED[i][7:0]);
            tx_gap();
        end
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering mixed text bytes and end-of-line commands
    task automatic test_backpressure();
        tx_quiet = 1'b1;
        rx_quiet = 1'b0;
        hold_req = 200;
        for (int i = 0; i < 24; i++) begin
            if (i % 6 == 5) send_item(CMD_EOL, 8'($urandom_range(255)));
            else send_item(CMD_DATA, pick_text_byte());
        end
        tx_quiet = 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        int len;
        int start_items;
        start_items = escaped_items;
        while (escaped_items - start_items < RANDOM_ITEMS) begin
            tx_quiet = ($urandom_range(7) == 0);
            rx_quiet = ($urandom_range(7) == 0);
            if ($urandom_range(99) < 80) begin
                len = $urandom_range(1, 20);
                repeat (len) begin
                    send_item(CMD_DATA, pick_text_byte());
                    tx_gap();
                end
                send_item(CMD_EOL, 8'($urandom_range(255)));
                tx_gap();
                if ($urandom_range(3) == 0) send_item(CMD_EOL, 8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
                    tx_gap();
                end
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && escaped_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/xbe_pkg.sv
src/xbe_front.sv
src/xbe_fifo.sv
src/xbe_back.sv
src/xml_byte_escaper.sv
sim/tb_xml_byte_escaper.sv
